/* rtl/core/sfr_pkg.sv */
// Shared types and constants for the streaming find/replace-all block.
// No dependencies; used by every module under rtl/core.
package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int MAX_REPLACE_DEF = 8;
    localparam int RES_MAX         = 8;
    localparam int LEN_W           = 4;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 5;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES = 2'd0,
        REG_PATTERN_LEN   = 2'd1,
        REG_REPLACE_BYTES = 2'd2,
        REG_REPLACE_LEN   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0] pattern_bytes;
        logic [LEN_W-1:0]  pattern_len;
        logic [DATA_W-1:0] replace_bytes;
        logic [LEN_W-1:0]  replace_len;
        logic              clear_window;
    } t_cfg;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]        count;
        logic                    last;
    } t_res_set;

endpackage

/* rtl/core/stream_find_replace_all_core.sv */
// Top level of the streaming find/replace-all block.
// Depends on sfr_pkg, sfr_regs, sfr_match and sfr_obuf.
//
// Usage:
//   Text enters one byte per request on the input channel (i_in_valid /
//   o_in_ready, payload i_in_item with in_byte and in_last). Rewritten text
//   leaves on the output channel (o_out_valid / i_out_ready, payload
//   o_out_item). run_last flags the last byte caused by one input request,
//   text_end the final byte of the text.
//   Pattern, replacement and their lengths are set over the APB-style port
//   and are to be written only while the block is idle, which the block
//   itself does not enforce; a pattern write restarts the search.
//   The first byte caused by a request is valid the cycle after it is
//   accepted. Plain text (zero or one byte per request) streams at one
//   byte per cycle while the receiver is ready. A request yielding n bytes
//   (n up to 8) holds the input until the one-byte output port drains them.
//   Reset: window empty, pattern one byte of zero, replacement empty.
//   A stalled receiver holds the current byte; input is taken again once the
//   last byte of the pending result set is taken.
module stream_find_replace_all_core #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  sfr_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output sfr_pkg::t_out_item         o_out_item,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic [sfr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sfr_pkg::t_cfg     cfg;
    sfr_pkg::t_res_set res_set;
    logic              in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfr_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_acc),
        .i_item   (i_in_item),
        .o_set    (res_set)
    );

    sfr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_set   (res_set),
        .o_take  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // a new request never overwrites bytes still waiting to go out
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!o_out_valid || (i_out_ready && o_out_item.run_last)))
        else $error("request accepted over pending result bytes");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.text_end) |-> o_out_item.run_last)
        else $error("text_end without run_last");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.run_last && !in_acc) |=> !o_out_valid)
        else $error("output valid after final byte with no new request");

endmodule

/* rtl/core/sfr_regs.sv */
// APB-style configuration registers: pattern, replacement and their lengths.
// Depends on sfr_pkg.
module sfr_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic [sfr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output sfr_pkg::t_cfg              o_cfg
);

    logic [sfr_pkg::DATA_W-1:0] r_pattern_bytes;
    logic [sfr_pkg::LEN_W-1:0]  r_pattern_len;
    logic [sfr_pkg::DATA_W-1:0] r_replace_bytes;
    logic [sfr_pkg::LEN_W-1:0]  r_replace_len;
    logic                       clr_win;
    logic                       wr_en;
    sfr_pkg::t_reg_idx          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = sfr_pkg::t_reg_idx'(paddr[4:3]);

    // window is dropped at the same edge that writes the pattern
    assign clr_win = wr_en &&
                     (idx inside {sfr_pkg::REG_PATTERN_BYTES, sfr_pkg::REG_PATTERN_LEN});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes <= '0;
            r_pattern_len   <= sfr_pkg::LEN_W'(1);
            r_replace_bytes <= '0;
            r_replace_len   <= '0;
        end else begin
            if (wr_en) begin
                case (idx)
                    sfr_pkg::REG_PATTERN_BYTES: begin
                        r_pattern_bytes <= pwdata;
                    end
                    sfr_pkg::REG_PATTERN_LEN: begin
                        r_pattern_len <= pwdata[sfr_pkg::LEN_W-1:0];
                    end
                    sfr_pkg::REG_REPLACE_BYTES: begin
                        r_replace_bytes <= pwdata;
                    end
                    sfr_pkg::REG_REPLACE_LEN: begin
                        r_replace_len <= pwdata[sfr_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (idx)
            sfr_pkg::REG_PATTERN_BYTES: prdata = r_pattern_bytes;
            sfr_pkg::REG_PATTERN_LEN:   prdata = sfr_pkg::DATA_W'(r_pattern_len);
            sfr_pkg::REG_REPLACE_BYTES: prdata = r_replace_bytes;
            sfr_pkg::REG_REPLACE_LEN:   prdata = sfr_pkg::DATA_W'(r_replace_len);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.pattern_bytes = r_pattern_bytes;
    assign o_cfg.pattern_len   = r_pattern_len;
    assign o_cfg.replace_bytes = r_replace_bytes;
    assign o_cfg.replace_len   = r_replace_len;
    assign o_cfg.clear_window  = clr_win;

endmodule

/* rtl/core/sfr_match.sv */
// Match window and single-pass compare: builds the result set of one request.
// Depends on sfr_pkg.
module sfr_match #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfr_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  sfr_pkg::t_in_item i_item,
    output sfr_pkg::t_res_set o_set
);

    localparam int PAT_LIMIT = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int REP_LIMIT = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;
    localparam int WC_W      = $clog2(PAT_LIMIT + 1);

    logic [7:0]                r_win [PAT_LIMIT];
    logic [7:0]                n_win [PAT_LIMIT];
    logic [7:0]                w     [PAT_LIMIT];
    logic [WC_W-1:0]           r_wcnt;
    logic [WC_W-1:0]           n_wcnt;
    logic [WC_W-1:0]           wc0;
    logic [WC_W-1:0]           wc1;
    logic [sfr_pkg::LEN_W-1:0] plen;
    logic [sfr_pkg::LEN_W-1:0] rlen;
    logic                      full;
    logic                      hit;

    always_comb begin
        plen = i_cfg.pattern_len;
        if (plen == '0) begin
            plen = sfr_pkg::LEN_W'(1);
        end
        if (plen > sfr_pkg::LEN_W'(PAT_LIMIT)) begin
            plen = sfr_pkg::LEN_W'(PAT_LIMIT);
        end
        rlen = i_cfg.replace_len;
        if (rlen > sfr_pkg::LEN_W'(REP_LIMIT)) begin
            rlen = sfr_pkg::LEN_W'(REP_LIMIT);
        end

        wc0 = (sfr_pkg::LEN_W'(r_wcnt) >= plen) ? '0 : r_wcnt;
        for (int i = 0; i < PAT_LIMIT; i++) begin
            w[i] = (WC_W'(i) == wc0) ? i_item.in_byte : r_win[i];
        end
        wc1  = wc0 + 1'b1;
        full = (sfr_pkg::LEN_W'(wc1) == plen);

        hit = full;
        for (int i = 0; i < PAT_LIMIT; i++) begin
            if (sfr_pkg::LEN_W'(i) < plen && w[i] != i_cfg.pattern_bytes[8*i +: 8]) begin
                hit = 1'b0;
            end
        end

        // on a hit the replacement goes out, otherwise the window from its oldest byte
        for (int k = 0; k < sfr_pkg::RES_MAX; k++) begin
            o_set.bytes[k] = i_cfg.replace_bytes[8*k +: 8];
        end
        if (!hit) begin
            for (int i = 0; i < PAT_LIMIT; i++) begin
                o_set.bytes[i] = w[i];
            end
        end
        if (hit) begin
            o_set.count = rlen;
        end else if (i_item.in_last) begin
            o_set.count = sfr_pkg::LEN_W'(wc1);
        end else if (full) begin
            o_set.count = sfr_pkg::LEN_W'(1);
        end else begin
            o_set.count = '0;
        end
        o_set.last = i_item.in_last;

        n_win = w;
        if (full) begin
            for (int i = 0; i < PAT_LIMIT - 1; i++) begin
                n_win[i] = w[i + 1];
            end
        end
        if (hit || i_item.in_last) begin
            n_wcnt = '0;
        end else if (full) begin
            n_wcnt = wc1 - 1'b1;
        end else begin
            n_wcnt = wc1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
        end else if (i_cfg.clear_window) begin
            r_wcnt <= '0;
        end else if (i_accept) begin
            r_wcnt <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

/* rtl/core/sfr_obuf.sv */
// Result buffer: holds up to eight result bytes and hands them out one per cycle while i_ready is high.
// Depends on sfr_pkg.
module sfr_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sfr_pkg::t_res_set  i_set,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_ready,
    output sfr_pkg::t_out_item o_item
);

    logic [sfr_pkg::RES_MAX-1:0][7:0] r_buf;
    logic [sfr_pkg::LEN_W-1:0]        r_cnt;
    logic                             r_last;
    logic                             pop;
    logic                             at_end;

    assign at_end  = (r_cnt == sfr_pkg::LEN_W'(1));
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_take  = (r_cnt == '0) || (at_end && i_ready);

    assign o_item.out_byte = r_buf[0];
    assign o_item.run_last = at_end;
    assign o_item.text_end = at_end && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_set.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf  <= i_set.bytes;
            r_last <= i_set.last;
        end else if (pop) begin
            r_buf <= r_buf >> 8;
        end
    end

endmodule

/* sim/tb_stream_find_replace_all_core.sv */
// Testbench for stream_find_replace_all_core: directed and random texts with a byte-level
// rewrite predictor, random stalls on both channels, and APB writes between phases.
// Depends on sfr_pkg and the RTL under rtl/core.
module tb_stream_find_replace_all_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 16;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    sfr_pkg::t_in_item          i_in_item = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    sfr_pkg::t_out_item         o_out_item;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [sfr_pkg::ADDR_W-1:0] paddr = '0;
    logic [sfr_pkg::DATA_W-1:0] pwdata = '0;
    logic [sfr_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    stream_find_replace_all_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0]        pat_word = '0;
    logic [3:0]         pat_len_reg = 4'd1;
    logic [63:0]        rep_word = '0;
    logic [3:0]         rep_len_reg = 4'd0;
    logic [7:0]         window_bytes [8];
    int                 window_fill = 0;
    sfr_pkg::t_out_item rewritten_q [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int in_gap_max = 3;
    int out_gap_max = 3;
    int out_gap = 0;

    function automatic int match_len();
        if (pat_len_reg == 4'd0) return 1;
        if (pat_len_reg > 4'd8) return 8;
        return int'(pat_len_reg);
    endfunction

    function automatic int subst_len();
        if (rep_len_reg > 4'd8) return 8;
        return int'(rep_len_reg);
    endfunction

    task automatic clear_window();
        foreach (window_bytes[i]) window_bytes[i] = 8'h00;
        window_fill = 0;
    endtask

    task automatic rewrite_byte(input logic [7:0] b, input logic last);
        int                 plen;
        bit                 hit;
        logic [7:0]         produced [$];
        sfr_pkg::t_out_item r;
        plen = match_len();
        if (window_fill >= plen) window_fill = 0;
        window_bytes[window_fill] = b;
        window_fill++;
        if (window_fill == plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
                if (window_bytes[i] != pat_word[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                for (int i = 0; i < subst_len(); i++) produced.push_back(rep_word[8*i +: 8]);
                window_fill = 0;
            end else begin
                produced.push_back(window_bytes[0]);
                for (int i = 1; i < window_fill; i++) window_bytes[i-1] = window_bytes[i];
                window_fill--;
            end
        end
        if (last) begin
            for (int i = 0; i < window_fill; i++) produced.push_back(window_bytes[i]);
            window_fill = 0;
        end
        foreach (produced[i]) begin
            r.out_byte = produced[i];
            r.run_last = (i == produced.size() - 1);
            r.text_end = (i == produced.size() - 1) && last;
            rewritten_q.push_back(r);
        end
    endtask

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap = 0;
        end else if (i_out_ready && o_out_valid) begin
            out_gap = $urandom_range(0, out_gap_max);
            i_out_ready <= (out_gap == 0);
        end else if (!i_out_ready) begin
            if (out_gap > 0) out_gap = out_gap - 1;
            i_out_ready <= (out_gap == 0);
        end
    end

    sfr_pkg::t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rewritten_q.size() == 0) begin
                $display("%0t: out_byte expected none got %02h", $time,
                         o_out_item.out_byte);
                mismatch_count++;
            end else begin
                want = rewritten_q.pop_front();
                if (o_out_item.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h", $time,
                             want.out_byte, o_out_item.out_byte);
                    mismatch_count++;
                end
                if (o_out_item.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %0b got %0b", $time,
                             want.run_last, o_out_item.run_last);
                    mismatch_count++;
                end
                if (o_out_item.text_end !== want.text_end) begin
                    $display("%0t: text_end expected %0b got %0b", $time,
                             want.text_end, o_out_item.text_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stream_find_replace_all_core verification failed");
            $finish;
        end
    end

    // one input request; returns at the edge where it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{in_byte: b, in_last: last};
        rewrite_byte(b, last);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_block();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic apb_write(input sfr_pkg::t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sfr_pkg::REG_PATTERN_BYTES: begin pat_word = val; clear_window(); end
            sfr_pkg::REG_PATTERN_LEN:   begin pat_len_reg = val[3:0]; clear_window(); end
            sfr_pkg::REG_REPLACE_BYTES: rep_word = val;
            sfr_pkg::REG_REPLACE_LEN:   rep_len_reg = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_rewrite(input logic [63:0] pat, input logic [3:0] plen,
                               input logic [63:0] rep, input logic [3:0] rlen);
        drain_block();
        apb_write(sfr_pkg::REG_PATTERN_BYTES, pat);
        apb_write(sfr_pkg::REG_PATTERN_LEN, {60'd0, plen});
        apb_write(sfr_pkg::REG_REPLACE_BYTES, rep);
        apb_write(sfr_pkg::REG_REPLACE_LEN, {60'd0, rlen});
    endtask

    // reset config: pattern is one zero byte, matches are deleted; the last
    // request completes a match and so yields nothing at all
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_length_limits();
        // zero pattern length acts as one, oversized replacement clips to 8
        set_rewrite(64'h0000_0000_0000_00FF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        // oversized pattern length clips to 8, full-width match deleted at text end
        set_rewrite(64'hFEDC_BA98_7654_3210, 4'd15, 64'h0, 4'd0);
        for (int k = 0; k < 8; k++) send_byte(pat_word[8*k +: 8], k == 7);
        send_byte(8'h55, 1'b1);
    endtask

    // pattern write in the middle of a text drops the partial match
    task automatic test_pattern_change();
        set_rewrite(64'h0000_0000_0063_6261, 4'd3, 64'h58, 4'd1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        drain_block();
        apb_write(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        send_byte(8'h63, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
    endtask

    task automatic test_random_texts(input int phase_items, input int phases);
        int          sent;
        int          tlen;
        int          pl;
        int          cut;
        logic [3:0]  plen_w;
        logic [3:0]  rlen_w;
        logic [7:0]  text [$];
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: begin plen_w = 4'd8; rlen_w = 4'd8; end
                1: begin plen_w = 4'd1; rlen_w = 4'd0; end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: plen_w = 4'($urandom_range(1, 4));
                        6, 7:             plen_w = 4'($urandom_range(5, 8));
                        8:                plen_w = 4'd0;
                        default:          plen_w = 4'($urandom_range(9, 15));
                    endcase
                    rlen_w = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(0, 8));
                end
            endcase
            set_rewrite({$urandom, $urandom}, plen_w, {$urandom, $urandom}, rlen_w);
            in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 3;
            out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
            pl = match_len();
            sent = 0;
            while (sent < phase_items) begin
                tlen = $urandom_range(1, 12);
                text.delete();
                while (text.size() < tlen) begin
                    case ($urandom_range(0, 3))
                        0: for (int k = 0; k < pl; k++) text.push_back(pat_word[8*k +: 8]);
                        1: begin
                            cut = (pl > 1) ? $urandom_range(1, pl - 1) : 0;
                            for (int k = 0; k < cut; k++) text.push_back(pat_word[8*k +: 8]);
                            text.push_back(8'($urandom_range(0, 255)));
                        end
                        2: text.push_back(8'($urandom_range(0, 255)));
                        default: text.push_back(pat_word[8*$urandom_range(0, pl - 1) +: 8]);
                    endcase
                end
                foreach (text[k]) send_byte(text[k], k == text.size() - 1);
                sent += text.size();
            end
        end
    endtask

    initial begin
        clear_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_length_limits();
        test_pattern_change();
        test_random_texts(25, 10);
        drain_block();
        if (mismatch_count == 0) begin
            $display("stream_find_replace_all_core verification clean");
        end else begin
            $display("stream_find_replace_all_core verification failed");
        end
        $finish;
    end

endmodule

/* stream_find_replace_all_core.f */
rtl/core/sfr_pkg.sv
rtl/core/sfr_regs.sv
rtl/core/sfr_match.sv
rtl/core/sfr_obuf.sv
rtl/core/stream_find_replace_all_core.sv
sim/tb_stream_find_replace_all_core.sv
